FILE: hdl/cspe_pkg.sv
// Shared types, constants and saturating arithmetic for the cubic spline pair evaluator.
`default_nettype none

package cspe_pkg;

    localparam int SEGMENTS    = 64;
    localparam int SEG_W       = $clog2(SEGMENTS);
    localparam int COEF_W      = 64;
    localparam int POS_W       = 32;
    localparam int DIFF_W      = POS_W + 1;
    localparam int SPACE_W     = 31;
    localparam int CNT_W       = 7;
    localparam int DX_W        = 40;
    localparam int TERMS       = 4;
    localparam int AXES        = 2;
    localparam int BANKS       = AXES * TERMS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        REG_Z_FIRST       = 2'd0,
        REG_SPACING       = 2'd1,
        REG_INV_SPACING   = 2'd2,
        REG_SEGMENT_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic              axis;
        logic [1:0]        term;
        logic [SEG_W-1:0]  seg;
        logic [COEF_W-1:0] value;
        logic [DX_W-1:0]   dx;
    } job_t;

    function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                  input logic [COEF_W-1:0] b);
        logic [COEF_W:0] s;
        s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (s[COEF_W] != s[COEF_W-1])
        begin
            sat_add = s[COEF_W] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            sat_add = s[COEF_W-1:0];
        end
    endfunction

    // Q24.40 to Q16.16: floor by an arithmetic shift, then saturate to 32 bits.
    function automatic logic [POS_W-1:0] to_q16(input logic [COEF_W-1:0] v);
        logic [COEF_W-25:0] t;
        t = v[COEF_W-1:24];
        if (!t[COEF_W-25] && (t[COEF_W-26:POS_W-1] != '0))
        begin
            to_q16 = {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (t[COEF_W-25] && (t[COEF_W-26:POS_W-1] != '1))
        begin
            to_q16 = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            to_q16 = t[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cspe_front.sv
// Front end: configuration registers, item intake and segment and offset computation.
`default_nettype none

module cspe_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cspe_pkg::cmd_t                in_cmd,
    input  wire logic [cspe_pkg::POS_W-1:0]    in_z,
    input  wire logic                          in_axis,
    input  wire logic [cspe_pkg::SEG_W-1:0]    in_seg,
    input  wire logic [1:0]                    in_term,
    input  wire logic [cspe_pkg::COEF_W-1:0]   in_value,
    input  wire logic                          cfg_valid,
    input  wire cspe_pkg::cfg_reg_t            cfg_index,
    input  wire logic [cspe_pkg::POS_W-1:0]    cfg_data,
    input  wire logic                          q_full,
    output logic                               push,
    output cspe_pkg::job_t                     push_job
);

    localparam int DW   = cspe_pkg::DIFF_W;
    localparam int SPW  = cspe_pkg::SEG_W + cspe_pkg::SPACE_W;

    logic [cspe_pkg::POS_W-1:0]   z_first_reg;
    logic [cspe_pkg::SPACE_W-1:0] spacing_reg;
    logic [cspe_pkg::POS_W-1:0]   inv_reg;
    logic [cspe_pkg::CNT_W-1:0]   count_reg;

    logic                  f1_vld_reg, f2_vld_reg, f3_vld_reg;
    cspe_pkg::job_t        f1_job_reg, f2_job_reg, f3_job_reg;
    cspe_pkg::job_t        f1_job_next, f3_job_next;
    logic [DW-1:0]         f1_diff_reg, f2_diff_reg, f3_diff_reg;
    logic [DW-1:0]         f1_diff_next;
    logic [2*cspe_pkg::POS_W-1:0] f2_prod_reg, f2_prod_next;
    logic [cspe_pkg::SEG_W-1:0]   last_seg;
    logic [15:0]           seg_raw;
    logic [SPW-1:0]        span;
    logic                  fe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_first_reg <= '0;
            spacing_reg <= cspe_pkg::SPACE_W'(65536);
            inv_reg     <= '1;
            count_reg   <= cspe_pkg::CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cspe_pkg::REG_Z_FIRST:       z_first_reg <= cfg_data;
                cspe_pkg::REG_SPACING:       spacing_reg <= cfg_data[cspe_pkg::SPACE_W-1:0];
                cspe_pkg::REG_INV_SPACING:   inv_reg     <= cfg_data;
                cspe_pkg::REG_SEGMENT_COUNT: count_reg   <= cfg_data[cspe_pkg::CNT_W-1:0];
                default:                     z_first_reg <= z_first_reg;
            endcase
        end
    end

    // All three stages move together whenever the last one can drain.
    assign fe       = !f3_vld_reg || !q_full;
    assign in_ready = fe;
    assign push     = f3_vld_reg && !q_full;

    always_comb
    begin
        f1_job_next       = '0;
        f1_job_next.cmd   = in_cmd;
        f1_job_next.axis  = in_axis;
        f1_job_next.term  = in_term;
        f1_job_next.seg   = in_seg;
        f1_job_next.value = in_value;
        f1_diff_next = {in_z[cspe_pkg::POS_W-1], in_z}
                     - {z_first_reg[cspe_pkg::POS_W-1], z_first_reg};
        f2_prod_next = f1_diff_reg[cspe_pkg::POS_W-1:0] * inv_reg;
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            last_seg = '0;
        end
        else if (count_reg > cspe_pkg::CNT_W'(cspe_pkg::SEGMENTS))
        begin
            last_seg = cspe_pkg::SEG_W'(cspe_pkg::SEGMENTS - 1);
        end
        else
        begin
            last_seg = cspe_pkg::SEG_W'(count_reg - 1'b1);
        end
        // A position below the first knot falls into the first segment.
        seg_raw     = f2_diff_reg[DW-1] ? 16'd0 : f2_prod_reg[63:48];
        f3_job_next = f2_job_reg;
        if (f2_job_reg.cmd == cspe_pkg::CMD_EVAL)
        begin
            f3_job_next.seg = (seg_raw > 16'(last_seg)) ? last_seg
                                                       : seg_raw[cspe_pkg::SEG_W-1:0];
        end
    end

    always_comb
    begin
        span        = f3_job_reg.seg * spacing_reg;
        push_job    = f3_job_reg;
        push_job.dx = {{(cspe_pkg::DX_W-DW){f3_diff_reg[DW-1]}}, f3_diff_reg}
                    - {{(cspe_pkg::DX_W-SPW){1'b0}}, span};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            f1_job_reg  <= f1_job_next;
            f1_diff_reg <= f1_diff_next;
            f2_job_reg  <= f1_job_reg;
            f2_diff_reg <= f1_diff_reg;
            f2_prod_reg <= f2_prod_next;
            f3_job_reg  <= f3_job_next;
            f3_diff_reg <= f2_diff_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cspe_queue.sv
// Short job queue between the front end and the evaluation back end.
`default_nettype none

module cspe_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cspe_pkg::job_t push_job,
    input  wire logic           pop,
    output cspe_pkg::job_t      head,
    output logic                full,
    output logic                empty
);

    cspe_pkg::job_t                slot_reg [cspe_pkg::QUEUE_DEPTH];
    logic [cspe_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [cspe_pkg::QPTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (cspe_pkg::QPTR_W+1)'(cspe_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cspe_horner.sv
// One Horner step: y = sat(floor(a*dx / 2^16) + c), four pipeline stages.
`default_nettype none

module cspe_horner
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cspe_pkg::COEF_W-1:0]   a,
    input  wire logic [cspe_pkg::DX_W-1:0]     dx,
    input  wire logic [cspe_pkg::COEF_W-1:0]   c,
    output logic [cspe_pkg::COEF_W-1:0]        y
);

    localparam int CW     = cspe_pkg::COEF_W;
    localparam int AL_W   = CW / 2;
    localparam int AH_W   = CW - AL_W;
    localparam int BL_W   = cspe_pkg::DX_W / 2;
    localparam int BH_W   = cspe_pkg::DX_W - BL_W;
    localparam int PLL_W  = AL_W + BL_W;
    localparam int PLH_W  = AL_W + 1 + BH_W;
    localparam int PHL_W  = AH_W + BL_W + 1;
    localparam int PHH_W  = AH_W + BH_W;
    localparam int SUM_W  = PLH_W + BL_W + 1;
    localparam int FULL_W = SUM_W + AL_W;
    localparam int Q_W    = FULL_W - 16;

    logic [PLL_W-1:0]  p_ll_reg, p_ll_next;
    logic [PLH_W-1:0]  p_lh_reg, p_lh_next;
    logic [PHL_W-1:0]  p_hl_reg, p_hl_next;
    logic [PHH_W-1:0]  p_hh_reg, p_hh_next;
    logic [SUM_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [FULL_W-1:0] full;
    logic [Q_W-1:0]    q;
    logic [Q_W-CW:0]   upper;
    logic [CW-1:0]     m_reg, m_next;
    logic [CW-1:0]     c_p_reg, c_s1_reg, c_s2_reg;
    logic [CW-1:0]     y_reg;

    // Signed operands are split into an unsigned low half and a signed high half.
    always_comb
    begin
        p_ll_next = a[AL_W-1:0] * dx[BL_W-1:0];
        p_lh_next = $signed({1'b0, a[AL_W-1:0]}) * $signed(dx[cspe_pkg::DX_W-1:BL_W]);
        p_hl_next = $signed(a[CW-1:AL_W]) * $signed({1'b0, dx[BL_W-1:0]});
        p_hh_next = $signed(a[CW-1:AL_W]) * $signed(dx[cspe_pkg::DX_W-1:BL_W]);
    end

    always_comb
    begin
        lo_next = {{(SUM_W-PLL_W){1'b0}}, p_ll_reg}
                + {{(SUM_W-PLH_W-BL_W){p_lh_reg[PLH_W-1]}}, p_lh_reg, {BL_W{1'b0}}};
        hi_next = {{(SUM_W-PHL_W){p_hl_reg[PHL_W-1]}}, p_hl_reg}
                + {{(SUM_W-PHH_W-BL_W){p_hh_reg[PHH_W-1]}}, p_hh_reg, {BL_W{1'b0}}};
    end

    always_comb
    begin
        full  = {hi_reg, {AL_W{1'b0}}} + {{AL_W{lo_reg[SUM_W-1]}}, lo_reg};
        q     = full[FULL_W-1:16];
        upper = q[Q_W-1:CW-1];
        if ((upper == '0) || (upper == '1))
        begin
            m_next = q[CW-1:0];
        end
        else
        begin
            m_next = q[Q_W-1] ? cspe_pkg::COEF_MIN : cspe_pkg::COEF_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ll_reg <= p_ll_next;
            p_lh_reg <= p_lh_next;
            p_hl_reg <= p_hl_next;
            p_hh_reg <= p_hh_next;
            c_p_reg  <= c;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            c_s1_reg <= c_p_reg;
            m_reg    <= m_next;
            c_s2_reg <= c_s1_reg;
            y_reg    <= cspe_pkg::sat_add(m_reg, c_s2_reg);
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

FILE: hdl/cspe_back.sv
// Back end: coefficient memory, Horner pipelines for both splines and the output register.
`default_nettype none

module cspe_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cspe_pkg::job_t                head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cspe_pkg::POS_W-1:0]         width_x,
    output logic [cspe_pkg::POS_W-1:0]         width_y,
    output logic [cspe_pkg::POS_W-1:0]         slope_x,
    output logic [cspe_pkg::POS_W-1:0]         slope_y,
    output logic [cspe_pkg::SEG_W-1:0]         segment_used
);

    localparam int CW      = cspe_pkg::COEF_W;
    localparam int AX      = cspe_pkg::AXES;
    localparam int TM      = cspe_pkg::TERMS;
    localparam int STEP    = 4;
    localparam int SIDE_N  = 3 * STEP + 1;

    typedef struct packed
    {
        logic [cspe_pkg::SEG_W-1:0] seg;
        logic [cspe_pkg::DX_W-1:0]  dx;
        logic [AX-1:0][CW-1:0]      c0;
        logic [AX-1:0][CW-1:0]      c1;
        logic [AX-1:0][CW-1:0]      c2;
        logic [AX-1:0][CW-1:0]      c3;
        logic [AX-1:0][CW-1:0]      c3x;
        logic [AX-1:0][CW-1:0]      c2x;
    } side_t;

    logic [CW-1:0]              coef_mem [cspe_pkg::BANKS][cspe_pkg::SEGMENTS];
    logic [CW-1:0]              rd_reg   [cspe_pkg::BANKS];
    logic                       r_vld_reg;
    logic [cspe_pkg::SEG_W-1:0] r_seg_reg;
    logic [cspe_pkg::DX_W-1:0]  r_dx_reg;
    side_t                      prep;
    side_t                      side_reg [SIDE_N];
    logic [SIDE_N-1:0]          vld_reg;
    logic [AX-1:0][CW-1:0]      h1, h2, h3, g2, g3;
    logic                       be;
    logic                       out_vld_reg;
    logic [cspe_pkg::POS_W-1:0] wx_reg, wy_reg, sx_reg, sy_reg;
    logic [cspe_pkg::SEG_W-1:0] seg_out_reg;

    assign be  = !out_vld_reg || out_ready;
    assign pop = be && !empty;

    // Writes and reads leave the queue in order, so a read always sees earlier writes.
    always_ff @(posedge clk)
    begin
        if (pop && (head.cmd == cspe_pkg::CMD_WRITE))
        begin
            coef_mem[{head.axis, head.term}][head.seg] <= head.value;
        end
        if (pop)
        begin
            for (int b = 0; b < cspe_pkg::BANKS; b++)
            begin
                rd_reg[b] <= coef_mem[b][head.seg];
            end
            r_seg_reg <= head.seg;
            r_dx_reg  <= head.dx;
        end
    end

    always_comb
    begin
        prep.seg = r_seg_reg;
        prep.dx  = r_dx_reg;
        for (int a = 0; a < AX; a++)
        begin
            prep.c0[a]  = rd_reg[a*TM];
            prep.c1[a]  = rd_reg[a*TM+1];
            prep.c2[a]  = rd_reg[a*TM+2];
            prep.c3[a]  = rd_reg[a*TM+3];
            prep.c3x[a] = cspe_pkg::sat_add(cspe_pkg::sat_add(rd_reg[a*TM], rd_reg[a*TM]),
                                            rd_reg[a*TM]);
            prep.c2x[a] = cspe_pkg::sat_add(rd_reg[a*TM+1], rd_reg[a*TM+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg   <= 1'b0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (be)
        begin
            r_vld_reg   <= pop && (head.cmd == cspe_pkg::CMD_EVAL);
            vld_reg     <= {vld_reg[SIDE_N-2:0], r_vld_reg};
            out_vld_reg <= vld_reg[SIDE_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            side_reg[0] <= prep;
            for (int i = 1; i < SIDE_N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            wx_reg      <= cspe_pkg::to_q16(h3[0]);
            wy_reg      <= cspe_pkg::to_q16(h3[1]);
            sx_reg      <= cspe_pkg::to_q16(g3[0]);
            sy_reg      <= cspe_pkg::to_q16(g3[1]);
            seg_out_reg <= side_reg[SIDE_N-1].seg;
        end
    end

    // The derivative runs one step behind so both chains finish together.
    for (genvar a = 0; a < AX; a++)
    begin : g_axis
        cspe_horner u_v1
        (
            .clk (clk), .en (be),
            .a   (side_reg[0].c0[a]), .dx (side_reg[0].dx), .c (side_reg[0].c1[a]),
            .y   (h1[a])
        );
        cspe_horner u_v2
        (
            .clk (clk), .en (be),
            .a   (h1[a]), .dx (side_reg[STEP].dx), .c (side_reg[STEP].c2[a]),
            .y   (h2[a])
        );
        cspe_horner u_d2
        (
            .clk (clk), .en (be),
            .a   (side_reg[STEP].c3x[a]), .dx (side_reg[STEP].dx),
            .c   (side_reg[STEP].c2x[a]),
            .y   (g2[a])
        );
        cspe_horner u_v3
        (
            .clk (clk), .en (be),
            .a   (h2[a]), .dx (side_reg[2*STEP].dx), .c (side_reg[2*STEP].c3[a]),
            .y   (h3[a])
        );
        cspe_horner u_d3
        (
            .clk (clk), .en (be),
            .a   (g2[a]), .dx (side_reg[2*STEP].dx), .c (side_reg[2*STEP].c2[a]),
            .y   (g3[a])
        );
    end

    assign out_valid    = out_vld_reg;
    assign width_x      = wx_reg;
    assign width_y      = wy_reg;
    assign slope_x      = sx_reg;
    assign slope_y      = sy_reg;
    assign segment_used = seg_out_reg;

endmodule

`default_nettype wire

FILE: hdl/cubic_spline_pair_evaluator_unit.sv
// Top level of the cubic spline pair evaluator: stream ports and the three main parts.
`default_nettype none

// Evaluates the x and y width splines and their slopes at a Q16.16 axial position, and
// loads Q24.40 coefficients through the same input stream (tuser low: write, high:
// evaluate). One transaction is taken per clock cycle as long as the output side keeps
// up; the figure is set by the fully pipelined front end (three stages) and the Horner
// pipeline in the back end, where every 64 by 40 bit multiply is split into four partial
// products and each Horner step takes four stages. Writes and evaluations are carried out
// strictly in arrival order, and a four-entry queue between front and back lets each
// side stall on its own. The coefficient memory is eight banks of 64 entries and has no
// reset; evaluate only segments whose coefficients have been written. Configuration
// writes take effect at once and are meant to be issued while no evaluation is in flight.
module cubic_spline_pair_evaluator_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // z_pos[31:0], coeff_axis[32], coeff_segment[38:33], coeff_term[40:39],
    // coeff_value[104:41], zero fill [111:105]
    input  wire logic [111:0]  s_tdata,
    // command[0]
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // width_x[31:0], width_y[63:32], slope_x[95:64], slope_y[127:96],
    // segment_used[133:128], zero fill [135:134]
    output logic [135:0]       m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    logic                           push, pop, q_full, q_empty;
    cspe_pkg::job_t                 push_job, head;
    logic [cspe_pkg::POS_W-1:0]     width_x, width_y, slope_x, slope_y;
    logic [cspe_pkg::SEG_W-1:0]     segment_used;

    assign cfg_ready = 1'b1;

    cspe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cspe_pkg::cmd_t'(s_tuser)),
        .in_z      (s_tdata[31:0]),
        .in_axis   (s_tdata[32]),
        .in_seg    (s_tdata[38:33]),
        .in_term   (s_tdata[40:39]),
        .in_value  (s_tdata[104:41]),
        .cfg_valid (cfg_valid),
        .cfg_index (cspe_pkg::cfg_reg_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    cspe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    cspe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .width_x      (width_x),
        .width_y      (width_y),
        .slope_x      (slope_x),
        .slope_y      (slope_y),
        .segment_used (segment_used)
    );

    assign m_tdata = {2'b00, segment_used, slope_y, slope_x, width_y, width_x};

endmodule

`default_nettype wire
